// File: hw/rtl/coupled_inertia_plant_with_delay_unit_defines.svh
// Assertion macros shared by the plant RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef COUPLED_INERTIA_PLANT_WITH_DELAY_UNIT_DEFINES_SVH
`define COUPLED_INERTIA_PLANT_WITH_DELAY_UNIT_DEFINES_SVH
// Check a property on every clock edge outside reset.
`define CIP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define CIP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: hw/rtl/cip_pkg.sv
// Package for the coupled inertia plant: payload types, register codes, sine table.
// Depends on nothing.
package cip_pkg;

  // Plant dimensions; the payload structs below are sized for them
  localparam int MaxChannels  = 8;
  localparam int HistoryDepth = 32;

  typedef struct packed {
    logic signed [15:0] motor_7;
    logic signed [15:0] motor_6;
    logic signed [15:0] motor_5;
    logic signed [15:0] motor_4;
    logic signed [15:0] motor_3;
    logic signed [15:0] motor_2;
    logic signed [15:0] motor_1;
    logic signed [15:0] motor_0;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sensor_8;
    logic signed [15:0] sensor_7;
    logic signed [15:0] sensor_6;
    logic signed [15:0] sensor_5;
    logic signed [15:0] sensor_4;
    logic signed [15:0] sensor_3;
    logic signed [15:0] sensor_2;
    logic signed [15:0] sensor_1;
    logic signed [15:0] sensor_0;
  } out_item_t;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 18;
  localparam logic [CfgIdxW-1:0] RegChannels   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSineMode   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegInertia    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCorrelation = 3'd3;
  localparam logic [CfgIdxW-1:0] RegZeroLast   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDelay      = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPhaseStep  = 3'd6;

  // Quarter-wave sine, round(32767*sin(k*pi/128)), k = 0..64
  function automatic logic [14:0] quarter_sine(input logic [6:0] k);
    logic [14:0] v;
    case (k)
      7'd0: v = 15'd0; 7'd1: v = 15'd804; 7'd2: v = 15'd1608; 7'd3: v = 15'd2410;
      7'd4: v = 15'd3212; 7'd5: v = 15'd4011; 7'd6: v = 15'd4808; 7'd7: v = 15'd5602;
      7'd8: v = 15'd6393; 7'd9: v = 15'd7179; 7'd10: v = 15'd7962; 7'd11: v = 15'd8739;
      7'd12: v = 15'd9512; 7'd13: v = 15'd10278; 7'd14: v = 15'd11039;
      7'd15: v = 15'd11793; 7'd16: v = 15'd12539; 7'd17: v = 15'd13278;
      7'd18: v = 15'd14010; 7'd19: v = 15'd14732; 7'd20: v = 15'd15446;
      7'd21: v = 15'd16151; 7'd22: v = 15'd16846; 7'd23: v = 15'd17530;
      7'd24: v = 15'd18204; 7'd25: v = 15'd18868; 7'd26: v = 15'd19519;
      7'd27: v = 15'd20159; 7'd28: v = 15'd20787; 7'd29: v = 15'd21403;
      7'd30: v = 15'd22005; 7'd31: v = 15'd22594; 7'd32: v = 15'd23170;
      7'd33: v = 15'd23731; 7'd34: v = 15'd24279; 7'd35: v = 15'd24811;
      7'd36: v = 15'd25329; 7'd37: v = 15'd25832; 7'd38: v = 15'd26319;
      7'd39: v = 15'd26790; 7'd40: v = 15'd27245; 7'd41: v = 15'd27683;
      7'd42: v = 15'd28105; 7'd43: v = 15'd28510; 7'd44: v = 15'd28898;
      7'd45: v = 15'd29268; 7'd46: v = 15'd29621; 7'd47: v = 15'd29956;
      7'd48: v = 15'd30273; 7'd49: v = 15'd30571; 7'd50: v = 15'd30852;
      7'd51: v = 15'd31113; 7'd52: v = 15'd31356; 7'd53: v = 15'd31580;
      7'd54: v = 15'd31785; 7'd55: v = 15'd31971; 7'd56: v = 15'd32137;
      7'd57: v = 15'd32285; 7'd58: v = 15'd32412; 7'd59: v = 15'd32521;
      7'd60: v = 15'd32609; 7'd61: v = 15'd32678; 7'd62: v = 15'd32728;
      7'd63: v = 15'd32757; 7'd64: v = 15'd32767;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // Sine of a 16-bit phase, Q1.15, from phase bits 15..8
  function automatic logic signed [15:0] sine_of(input logic [15:0] phase);
    logic [5:0] k;
    logic [14:0] mag;
    k = phase[13:8];
    mag = phase[14] ? quarter_sine(7'd64 - {1'b0, k}) : quarter_sine({1'b0, k});
    return phase[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

// File: hw/rtl/cip_mac.sv
// Shared multiply-accumulate: one 18x18 signed product per enabled cycle into a Q.31 sum.
// Depends on nothing; instantiated by the top level.
module cip_mac (
  input  logic               clk_i,
  input  logic               clear_i,
  input  logic               en_i,
  input  logic signed [17:0] a_i,
  input  logic signed [17:0] b_i,
  output logic signed [36:0] acc_o
);

  logic signed [35:0] prod;
  logic signed [36:0] acc_q;

  assign prod = a_i * b_i;

  // Add one product per enabled cycle; clear wins
  always_ff @(posedge clk_i) begin
    if (clear_i) begin
      acc_q <= '0;
    end else if (en_i) begin
      acc_q <= acc_q + 37'(prod);
    end
  end

  assign acc_o = acc_q;

endmodule

// File: hw/rtl/coupled_inertia_plant_with_delay_unit.sv
// Top level of the coupled inertia plant with loop delay.
// Depends on cip_pkg, cip_mac and the assertion macro header.
//
// Usage:
//   in_valid_i/in_ready_o move one motor vector (in_data_i); out_valid_o/
//   out_ready_i move one sensor vector (out_data_o). Each transfer in yields
//   exactly one transfer out. Configuration goes through cfg_we_i, cfg_idx_i
//   and cfg_data_i, one register per cycle; the user must write only while
//   the block is idle, and the block itself does not enforce it. Per item
//   the shared multiply-accumulate runs three products per channel plus a
//   commit, then one ring write and one ring read. One item is in work at
//   a time; in_ready_o is low from transfer in until the result has been
//   taken. If the receiver stalls, the result holds in the output register
//   and no further item is taken.
//   Reset clears the plant state, the history ring (through per-slot valid
//   bits, so no clearing pass), the write slot, the sine phase, and loads the
//   register defaults.
`include "coupled_inertia_plant_with_delay_unit_defines.svh"
module coupled_inertia_plant_with_delay_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cip_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cip_pkg::out_item_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [cip_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cip_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int NumCh  = cip_pkg::MaxChannels;
  localparam int Depth  = cip_pkg::HistoryDepth;
  localparam int VecLen = NumCh + 1;
  localparam int ChW    = 4;
  localparam int SlotW  = $clog2(Depth);
  localparam int ElW    = $clog2(VecLen);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMac   = 3'd1;
  localparam logic [2:0] StDrain = 3'd2;
  localparam logic [2:0] StWrite = 3'd3;
  localparam logic [2:0] StRead  = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  // Configuration registers
  logic [3:0]  channels_q;
  logic        sine_mode_q;
  logic [16:0] inertia_q;
  logic [17:0] correlation_q;
  logic        zero_last_q;
  logic [4:0]  delay_q;
  logic [15:0] phase_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channels_q    <= 4'd2;
      sine_mode_q   <= 1'b0;
      inertia_q     <= '0;
      correlation_q <= '0;
      zero_last_q   <= 1'b0;
      delay_q       <= 5'd1;
      phase_step_q  <= 16'd104;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cip_pkg::RegChannels:    channels_q    <= cfg_data_i[3:0];
        cip_pkg::RegSineMode:    sine_mode_q   <= cfg_data_i[0];
        cip_pkg::RegInertia:     inertia_q     <= cfg_data_i[16:0];
        cip_pkg::RegCorrelation: correlation_q <= cfg_data_i[17:0];
        cip_pkg::RegZeroLast:    zero_last_q   <= cfg_data_i[0];
        cip_pkg::RegDelay:       delay_q       <= cfg_data_i[4:0];
        cip_pkg::RegPhaseStep:   phase_step_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers to their legal ranges
  logic [ChW-1:0]     n_ch;
  logic signed [17:0] keep;
  logic signed [17:0] motor_w;
  logic signed [17:0] corr;
  logic [4:0]         dly;
  always_comb begin
    n_ch = (channels_q == 4'd0) ? 4'd1 :
           (channels_q > ChW'(NumCh)) ? ChW'(NumCh) : channels_q;
    keep = (inertia_q > 17'd65536) ? 18'sd65536 : $signed({1'b0, inertia_q});
    motor_w = 18'sd65536 - keep;
    corr = ($signed(correlation_q) > 18'sd65536) ? 18'sd65536 :
           ($signed(correlation_q) < -18'sd65536) ? -18'sd65536 : $signed(correlation_q);
    dly = (delay_q == 5'd0) ? 5'd1 :
          ({27'd0, delay_q} > Depth - 1) ? 5'(Depth - 1) : delay_q;
  end

  // Sequencer state
  logic [2:0]            state_q, state_d;
  logic [ChW-1:0]        ch_q;
  logic [1:0]            term_q;
  logic [SlotW-1:0]      wslot_q;
  logic [15:0]           phase_q;
  logic [Depth-1:0]      slot_vld_q;
  logic signed [15:0]    plant_q [NumCh];
  logic signed [15:0]    motor_q [8];
  logic [SlotW-1:0]      rslot_q;
  logic                  rd_vld_q;

  // MAC operand selection
  logic signed [17:0] mac_a;
  logic signed [17:0] mac_b;
  logic               mac_en, mac_clr;
  logic signed [36:0] acc;
  logic [ChW-1:0]     ch_nx;

  assign ch_nx = (ch_q + 4'd1 == n_ch) ? 4'd0 : ch_q + 4'd1;

  always_comb begin
    mac_a = '0;
    mac_b = '0;
    case (term_q)
      2'd0: begin
        mac_a = 18'(plant_q[ch_q[ElW-2:0]]);
        mac_b = keep;
      end
      2'd1: begin
        mac_a = 18'(motor_q[ch_q[2:0]]);
        mac_b = motor_w;
      end
      default: begin
        mac_a = corr;
        mac_b = 18'(plant_q[ch_nx[ElW-2:0]]);
      end
    endcase
  end

  // Accumulate during the three products, clear while idle and while committing
  assign mac_en  = (state_q == StMac);
  assign mac_clr = (state_q == StIdle) || (state_q == StDrain);

  cip_mac u_mac (
    .clk_i  (clk_i),
    .clear_i(mac_clr),
    .en_i   (mac_en),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  // Round and saturate the accumulated sum
  logic signed [21:0] rnd;
  logic signed [15:0] sat;
  logic signed [37:0] acc_r;
  always_comb begin
    acc_r = 38'(acc) + 38'sd32768;
    rnd   = acc_r[37:16];
    sat   = (rnd > 22'sd32767) ? 16'sh7fff :
            (rnd < -22'sd32768) ? 16'sh8000 : rnd[15:0];
  end

  // History ring memory, one vector per slot
  logic [VecLen*16-1:0] hist_mem [Depth];
  logic [VecLen*16-1:0] wr_vec, rd_vec_q;
  logic                 wr_en;
  logic [SlotW-1:0]     rd_addr;

  always_comb begin
    wr_vec = '0;
    for (int i = 0; i < NumCh; i++) begin
      if (ChW'(i) < n_ch) wr_vec[i*16 +: 16] = plant_q[i];
    end
    if (sine_mode_q) wr_vec[n_ch*16 +: 16] = cip_pkg::sine_of(phase_q);
  end

  // Ring depth is a power of two, so the slot wraps by its width
  assign wr_en = (state_q == StWrite);
  assign rd_addr = wslot_q + SlotW'(1) - SlotW'(dly);

  // Write in the write cycle, read the delayed slot in the next cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) hist_mem[wslot_q] <= wr_vec;
    if (state_q == StRead) rd_vec_q <= hist_mem[rslot_q];
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_valid_i) state_d = StMac;
      StMac:   if (term_q == 2'd2) state_d = StDrain;
      StDrain: state_d = (ch_q + 4'd1 == n_ch) ? StWrite : StMac;
      StWrite: state_d = StRead;
      StRead:  state_d = StOut;
      StOut:   if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      ch_q       <= '0;
      term_q     <= '0;
      wslot_q    <= '0;
      phase_q    <= '0;
      slot_vld_q <= '0;
      rslot_q    <= '0;
      rd_vld_q   <= 1'b0;
      for (int i = 0; i < NumCh; i++) plant_q[i] <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: begin
          ch_q   <= '0;
          term_q <= '0;
        end
        StMac: term_q <= term_q + 2'd1;
        StDrain: begin
          term_q <= '0;
          // Commit the channel, then step on
          if (zero_last_q && (ch_q + 4'd1 == n_ch)) plant_q[ch_q[ElW-2:0]] <= '0;
          else plant_q[ch_q[ElW-2:0]] <= sat;
          ch_q <= ch_q + 4'd1;
        end
        StWrite: begin
          slot_vld_q[wslot_q] <= 1'b1;
          if (sine_mode_q) phase_q <= phase_q + phase_step_q;
          rslot_q <= rd_addr;
        end
        StRead: begin
          wslot_q  <= (wslot_q == SlotW'(Depth - 1)) ? '0 : wslot_q + 1'b1;
          rd_vld_q <= slot_vld_q[rslot_q];
        end
        default: ;
      endcase
    end
  end

  // Hold the motor vector for the whole item
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      motor_q[0] <= in_data_i.motor_0; motor_q[1] <= in_data_i.motor_1;
      motor_q[2] <= in_data_i.motor_2; motor_q[3] <= in_data_i.motor_3;
      motor_q[4] <= in_data_i.motor_4; motor_q[5] <= in_data_i.motor_5;
      motor_q[6] <= in_data_i.motor_6; motor_q[7] <= in_data_i.motor_7;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_data_o  = rd_vld_q ? cip_pkg::out_item_t'(rd_vec_q) : '0;

  `CIP_ASSERT(a_out_only_in_out, clk_i, rst_ni,
    out_valid_o |-> !in_ready_o, "result shown while taking input")
  `CIP_ASSERT(a_write_then_read, clk_i, rst_ni,
    (state_q == StWrite) |=> (state_q == StRead), "write not followed by read")
  `CIP_ASSERT(a_ch_bound, clk_i, rst_ni,
    (state_q == StMac) |-> (ch_q < n_ch), "channel counter out of range")

endmodule

// File: tb/coupled_inertia_plant_with_delay_unit_tb.sv
// Coupled inertia plant with loop delay testbench: reset check, directed table, random items.
// Depends on cip_pkg and the coupled_inertia_plant_with_delay_unit RTL.
`timescale 1ns / 1ps
module coupled_inertia_plant_with_delay_unit_tb;

  localparam int NCH = cip_pkg::MaxChannels;
  localparam int DEPTH = cip_pkg::HistoryDepth;
  localparam int VLEN = NCH + 1;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  cip_pkg::in_item_t in_data_i;
  cip_pkg::out_item_t out_data_o;
  logic cfg_we_i;
  logic [cip_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [cip_pkg::CfgDataW-1:0] cfg_data_i;

  coupled_inertia_plant_with_delay_unit u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // Plant copy: registers and state
  logic [3:0] p_chan;
  logic p_sine;
  logic [16:0] p_inertia;
  logic [17:0] p_corr;
  logic p_zero;
  logic [4:0] p_delay;
  logic [15:0] p_step;
  logic signed [15:0] plant_st [VLEN];
  logic signed [15:0] ring [DEPTH][VLEN];
  int wr_slot;
  logic [15:0] phase;

  cip_pkg::out_item_t sensor_q[$];
  int mismatches;
  longint cycles;

  // Fixed table of quarter-wave sine, independent of the package
  localparam int QS[65] = '{
    0, 804, 1608, 2410, 3212, 4011, 4808, 5602, 6393, 7179, 7962, 8739,
    9512, 10278, 11039, 11793, 12539, 13278, 14010, 14732, 15446, 16151,
    16846, 17530, 18204, 18868, 19519, 20159, 20787, 21403, 22005, 22594,
    23170, 23731, 24279, 24811, 25329, 25832, 26319, 26790, 27245, 27683,
    28105, 28510, 28898, 29268, 29621, 29956, 30273, 30571, 30852, 31113,
    31356, 31580, 31785, 31971, 32137, 32285, 32412, 32521, 32609, 32678,
    32728, 32757, 32767};

  function automatic logic signed [15:0] sine_lookup(logic [15:0] ph);
    int k, v;
    k = ph[13:8];
    v = ph[14] ? QS[64 - k] : QS[k];
    return ph[15] ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic signed [15:0] round_clip(longint acc);
    longint r;
    r = (acc + 32768) >>> 16;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  task automatic plant_write(logic [cip_pkg::CfgIdxW-1:0] idx,
                             logic [cip_pkg::CfgDataW-1:0] val);
    case (idx)
      cip_pkg::RegChannels:    p_chan = val[3:0];
      cip_pkg::RegSineMode:    p_sine = val[0];
      cip_pkg::RegInertia:     p_inertia = val[16:0];
      cip_pkg::RegCorrelation: p_corr = val[17:0];
      cip_pkg::RegZeroLast:    p_zero = val[0];
      cip_pkg::RegDelay:       p_delay = val[4:0];
      cip_pkg::RegPhaseStep:   p_step = val[15:0];
      default: ;
    endcase
  endtask

  // Advance the plant by one motor vector, return the delayed sensor vector
  function automatic cip_pkg::out_item_t plant_step(cip_pkg::in_item_t m);
    logic signed [15:0] mv [NCH];
    logic signed [15:0] sv [VLEN];
    cip_pkg::out_item_t o;
    int n, d, rd;
    longint keep, corr, acc;
    mv = '{m.motor_0, m.motor_1, m.motor_2, m.motor_3,
           m.motor_4, m.motor_5, m.motor_6, m.motor_7};
    n = p_chan;
    if (n < 1) n = 1;
    if (n > NCH) n = NCH;
    keep = (p_inertia > 65536) ? 65536 : p_inertia;
    corr = longint'($signed(p_corr));
    if (corr > 65536) corr = 65536;
    if (corr < -65536) corr = -65536;
    for (int i = 0; i < n; i++) begin
      acc = longint'(plant_st[i]) * keep + longint'(mv[i]) * (65536 - keep)
          + corr * longint'(plant_st[(i + 1) % n]);
      plant_st[i] = round_clip(acc);
    end
    if (p_zero) plant_st[n - 1] = '0;
    for (int i = 0; i < VLEN; i++) ring[wr_slot][i] = (i < n) ? plant_st[i] : 16'sd0;
    if (p_sine) begin
      ring[wr_slot][n] = sine_lookup(phase);
      phase = phase + p_step;
    end
    wr_slot = (wr_slot + 1) % DEPTH;
    d = p_delay;
    if (d < 1) d = 1;
    if (d > DEPTH - 1) d = DEPTH - 1;
    rd = (wr_slot + DEPTH - d) % DEPTH;
    sv = ring[rd];
    o = {sv[8], sv[7], sv[6], sv[5], sv[4], sv[3], sv[2], sv[1], sv[0]};
    return o;
  endfunction

  // Clock and cycle guard
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Predict on each input transfer
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sensor_q = {sensor_q, plant_step(in_data_i)};
  end

  // Compare each output transfer with the oldest prediction
  always @(posedge clk_i) begin
    cip_pkg::out_item_t exp_v;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sensor_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sensor transfer %h", out_data_o);
      end else begin
        exp_v = sensor_q.pop_front();
        if (exp_v !== out_data_o) begin
          mismatches++;
          if (mismatches <= 10) $display("sensor mismatch exp %h got %h", exp_v, out_data_o);
        end
      end
    end
  end

  // Receiver: random stalls, mostly short, some long, some runs with none
  initial begin
    int gap;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      gap = $urandom_range(0, 9);
      if (gap < 4) out_ready_i <= 1'b1;
      else if (gap < 9) out_ready_i <= ($urandom_range(0, 2) != 0);
      else begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(20, 80)) @(negedge clk_i);
      end
    end
  end

  task automatic reg_write(logic [cip_pkg::CfgIdxW-1:0] idx,
                           logic [cip_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    plant_write(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sensor_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic send_vector(cip_pkg::in_item_t v);
    int gap;
    gap = $urandom_range(0, 15);
    if (gap > 12) repeat ($urandom_range(10, 60)) @(negedge clk_i);
    else if (gap > 6) repeat (gap - 6) @(negedge clk_i);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  function automatic cip_pkg::in_item_t rand_vector(int mode);
    cip_pkg::in_item_t v;
    for (int i = 0; i < NCH; i++) begin
      case (mode)
        0: v[i*16 +: 16] = 16'h7FFF;
        1: v[i*16 +: 16] = 16'h8000;
        default: v[i*16 +: 16] = 16'($urandom);
      endcase
    end
    return v;
  endfunction

  // Directed table: register setup then motor pattern
  typedef struct {
    logic [3:0] chan; logic sine; logic [16:0] inert; logic [17:0] corr;
    logic zl; logic [4:0] dly; logic [15:0] step; int pat;
  } dir_row_t;

  localparam int NDIR = 12;
  dir_row_t dir_tab [NDIR] = '{
    '{4'd2, 1'b0, 17'd0,     18'd0,      1'b0, 5'd1,  16'd104,   0},
    '{4'd8, 1'b0, 17'd0,     18'd0,      1'b0, 5'd1,  16'd0,     0},
    '{4'd8, 1'b0, 17'd0,     18'd0,      1'b0, 5'd1,  16'd0,     1},
    '{4'd8, 1'b1, 17'd65536, 18'd65536,  1'b0, 5'd3,  16'd16384, 0},
    '{4'd1, 1'b1, 17'd32768, 18'h30000,  1'b1, 5'd31, 16'd65535, 2},
    '{4'd0, 1'b0, 17'h1FFFF, 18'h1FFFF,  1'b0, 5'd0,  16'd4096,  0},
    '{4'd15, 1'b1, 17'd65535, 18'h20000, 1'b1, 5'd2,  16'd8192,  1},
    '{4'd9, 1'b0, 17'd1,     18'h3FFFF,  1'b0, 5'd31, 16'd1,     2},
    '{4'd3, 1'b1, 17'd40000, 18'd60000,  1'b1, 5'd4,  16'd256,   0},
    '{4'd5, 1'b1, 17'd0,     18'h10000,  1'b0, 5'd1,  16'd32768, 1},
    '{4'd8, 1'b1, 17'd65536, 18'd0,      1'b1, 5'd30, 16'd104,   2},
    '{4'd7, 1'b0, 17'd20000, 18'h3C000,  1'b0, 5'd5,  16'd777,   2}
  };

  task automatic apply_row(dir_row_t r);
    reg_write(cip_pkg::RegChannels, 18'(r.chan));
    reg_write(cip_pkg::RegSineMode, 18'(r.sine));
    reg_write(cip_pkg::RegInertia, 18'(r.inert));
    reg_write(cip_pkg::RegCorrelation, r.corr);
    reg_write(cip_pkg::RegZeroLast, 18'(r.zl));
    reg_write(cip_pkg::RegDelay, 18'(r.dly));
    reg_write(cip_pkg::RegPhaseStep, 18'(r.step));
  endtask

  // Stimulus
  initial begin
    cip_pkg::out_item_t first_exp;
    dir_row_t r;
    cycles = 0;
    mismatches = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = cip_pkg::RegChannels;
    cfg_data_i = '0;
    p_chan = 4'd2; p_sine = 1'b0; p_inertia = '0; p_corr = '0;
    p_zero = 1'b0; p_delay = 5'd1; p_step = 16'd104;
    for (int i = 0; i < VLEN; i++) plant_st[i] = '0;
    for (int s = 0; s < DEPTH; s++) for (int i = 0; i < VLEN; i++) ring[s][i] = '0;
    wr_slot = 0;
    phase = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Out of reset: inertia 0, two channels, full positive motor reads straight back
    first_exp = '0;
    first_exp.sensor_0 = 16'sh7FFF;
    first_exp.sensor_1 = 16'sh7FFF;
    send_vector(rand_vector(0));
    wait_idle();
    if (out_data_o !== first_exp) begin
      mismatches++;
      $display("reset-default mismatch exp %h got %h", first_exp, out_data_o);
    end

    // Walk the directed table
    for (int k = 0; k < NDIR; k++) begin
      r = dir_tab[k];
      apply_row(r);
      send_vector(rand_vector(r.pat));
      send_vector(rand_vector(r.pat == 2 ? 2 : 1 - r.pat));
      wait_idle();
    end

    // Random phases with random settings, extremes mixed in
    for (int ph = 0; ph < 16; ph++) begin
      r.chan = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
      r.sine = 1'($urandom);
      case ($urandom_range(0, 3))
        0: r.inert = 17'd65536;
        1: r.inert = 17'($urandom);
        default: r.inert = 17'($urandom_range(30000, 65536));
      endcase
      case ($urandom_range(0, 3))
        0: r.corr = 18'($urandom);
        1: r.corr = 18'h30000;
        default: r.corr = 18'($signed(18'($urandom_range(0, 12000)) - 18'd6000));
      endcase
      r.zl = 1'($urandom);
      r.dly = 5'($urandom);
      r.step = 16'($urandom);
      apply_row(r);
      for (int j = 0; j < 40; j++) begin
        // Hold off once mid-phase until every result has come back
        if (ph == 3 && j == 20) while (sensor_q.size() != 0) @(negedge clk_i);
        send_vector(rand_vector($urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : 2));
      end
      wait_idle();
    end

    if (mismatches == 0 && sensor_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: coupled_inertia_plant_with_delay_unit.f
+incdir+hw/rtl
hw/rtl/cip_pkg.sv
hw/rtl/cip_mac.sv
hw/rtl/coupled_inertia_plant_with_delay_unit.sv
tb/coupled_inertia_plant_with_delay_unit_tb.sv
